// ----- hw/rtl/s20r_pkg.sv -----
// Package with the types, tables and helpers of the reduced-round Salsa20 permutation.
`timescale 1ns / 1ps

package s20r_pkg;

  localparam int unsigned NumWords = 16;
  localparam int unsigned WordW    = 32;
  localparam int unsigned IdxW     = 4;
  localparam int unsigned RoundW   = 5;
  localparam int unsigned RotW     = 5;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 5;

  localparam logic [CfgIdxW-1:0] CfgRoundCount = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgInverse    = 1'b1;

  localparam logic [IdxW-1:0] LastIdx = 4'd15;

  localparam logic [RoundW-1:0] RoundReset = 5'd20;

  localparam logic [IdxW-1:0] ColSel [NumWords] = '{
    4'd0, 4'd4, 4'd8, 4'd12, 4'd5, 4'd9, 4'd13, 4'd1,
    4'd10, 4'd14, 4'd2, 4'd6, 4'd15, 4'd3, 4'd7, 4'd11
  };
  localparam logic [IdxW-1:0] RowSel [NumWords] = '{
    4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd6, 4'd7, 4'd4,
    4'd10, 4'd11, 4'd8, 4'd9, 4'd15, 4'd12, 4'd13, 4'd14
  };

  typedef struct packed {
    logic [WordW-1:0] word_value;
    logic [IdxW-1:0]  word_index;
  } req_t;

  typedef struct packed {
    logic [WordW-1:0] out_word;
    logic [IdxW-1:0]  out_index;
    logic             last_word;
  } res_t;

  typedef struct packed {
    logic             load;
    logic [WordW-1:0] load_word;
    logic             step;
    logic             inverse;
    logic [RotW-1:0]  rot;
  } qctl_t;

  typedef enum logic [1:0] {
    StIdle,
    StLoad,
    StCalc,
    StEmit
  } state_e;

  function automatic logic [IdxW-1:0] sel_idx(logic row, logic [1:0] grp, logic [1:0] pos);
    logic [IdxW-1:0] flat;
    flat = {grp, pos};
    return row ? RowSel[flat] : ColSel[flat];
  endfunction

  function automatic logic [RotW-1:0] rot_amt(logic [1:0] pos);
    logic [RotW-1:0] r;
    case (pos)
      2'd0:    r = 5'd18;
      2'd1:    r = 5'd7;
      2'd2:    r = 5'd9;
      2'd3:    r = 5'd13;
      default: r = 5'd18;
    endcase
    return r;
  endfunction

endpackage

// ----- hw/rtl/salsa20_reduced_round_permutation.sv -----
// Top level of the reduced-round Salsa20 permutation with its state memory and sequencer.
// A request with an index below 15 only stores its word and busy stays low.
// A request with index 15 starts a run of R rounds: per quarter-round the sequencer reads four
// words through the single memory read port into the shared unit and then steps that unit to
// update the four words. The sixteen results then follow in index order, one per cycle;
// busy falls as the last result shows. Reset sets R to 20 and forward mode.
`timescale 1ns / 1ps

module salsa20_reduced_round_permutation
  import s20r_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  req_t                req_i,
  output logic                res_valid_o,
  output res_t                res_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic [WordW-1:0] mem [NumWords];

  state_e           state_q, state_d;
  logic [RoundW-1:0] rem_q, rem_d;
  logic [1:0]       grp_q, grp_d;
  logic [2:0]       cnt_q, cnt_d;
  logic [IdxW-1:0]  eidx_q, eidx_d;
  logic             out_vld_q, out_vld_d;
  logic [IdxW-1:0]  oidx_q, oidx_d;
  logic [RoundW-1:0] round_count_q;
  logic             inverse_q;
  logic [WordW-1:0] rdata_q;

  logic             we, re, row;
  logic [IdxW-1:0]  waddr, raddr;
  logic [WordW-1:0] wdata;
  logic [1:0]       tgt;
  qctl_t            ctl;
  logic [WordW-1:0] step_word;

  s20r_qr_unit u_qr (
    .clk_i       (clk_i),
    .ctl_i       (ctl),
    .step_word_o (step_word)
  );

  assign row = inverse_q ? ~rem_q[0] : (round_count_q[0] ^ rem_q[0]);
  assign tgt = inverse_q ? 2'(2'd0 - cnt_q[1:0]) : 2'(cnt_q[1:0] + 2'd1);

  always_comb begin
    state_d       = state_q;
    rem_d         = rem_q;
    grp_d         = grp_q;
    cnt_d         = cnt_q;
    eidx_d        = eidx_q;
    out_vld_d     = 1'b0;
    oidx_d        = oidx_q;
    we            = 1'b0;
    waddr         = req_i.word_index;
    wdata         = req_i.word_value;
    re            = 1'b0;
    raddr         = eidx_q;
    ctl.load      = 1'b0;
    ctl.load_word = rdata_q;
    ctl.step      = 1'b0;
    ctl.inverse   = inverse_q;
    ctl.rot       = rot_amt(tgt);
    case (state_q)
      StIdle: begin
        if (start) begin
          we = 1'b1;
          if (req_i.word_index == LastIdx) begin
            rem_d  = round_count_q;
            grp_d  = 2'd0;
            cnt_d  = 3'd0;
            eidx_d = '0;
            state_d = (round_count_q == '0) ? StEmit : StLoad;
          end
        end
      end
      StLoad: begin
        re       = (cnt_q != 3'd4);
        raddr    = sel_idx(row, grp_q, 2'(cnt_q[1:0] + (inverse_q ? 2'd3 : 2'd0)));
        ctl.load = (cnt_q != 3'd0);
        if (cnt_q == 3'd4) begin
          cnt_d   = 3'd0;
          state_d = StCalc;
        end else begin
          cnt_d = 3'(cnt_q + 3'd1);
        end
      end
      StCalc: begin
        ctl.step = 1'b1;
        we       = 1'b1;
        waddr    = sel_idx(row, grp_q, tgt);
        wdata    = step_word;
        if (cnt_q[1:0] == 2'd3) begin
          cnt_d = 3'd0;
          grp_d = 2'(grp_q + 2'd1);
          if (grp_q == 2'd3) begin
            rem_d = 5'(rem_q - 5'd1);
            if (rem_q == 5'd1) begin
              eidx_d  = '0;
              state_d = StEmit;
            end else begin
              state_d = StLoad;
            end
          end else begin
            state_d = StLoad;
          end
        end else begin
          cnt_d = 3'(cnt_q + 3'd1);
        end
      end
      StEmit: begin
        re        = 1'b1;
        out_vld_d = 1'b1;
        oidx_d    = eidx_q;
        eidx_d    = 4'(eidx_q + 4'd1);
        if (eidx_q == LastIdx) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      rem_q     <= '0;
      grp_q     <= '0;
      cnt_q     <= '0;
      eidx_q    <= '0;
      out_vld_q <= 1'b0;
      oidx_q    <= '0;
    end else begin
      state_q   <= state_d;
      rem_q     <= rem_d;
      grp_q     <= grp_d;
      cnt_q     <= cnt_d;
      eidx_q    <= eidx_d;
      out_vld_q <= out_vld_d;
      oidx_q    <= oidx_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      round_count_q <= RoundReset;
      inverse_q     <= 1'b0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgRoundCount) begin
        round_count_q <= cfg_data_i;
      end
      if (cfg_index_i == CfgInverse) begin
        inverse_q <= cfg_data_i[0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  assign busy            = (state_q != StIdle);
  assign cfg_ready_o     = 1'b1;
  assign res_valid_o     = out_vld_q;
  assign res_o.out_word  = rdata_q;
  assign res_o.out_index = oidx_q;
  assign res_o.last_word = (oidx_q == LastIdx);

  a_res_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(state_q) == StEmit)
    else $error("Result strobe without an emit cycle.");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.last_word |=> !res_valid_o)
    else $error("Result strobe continues after the last word.");

  a_index_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last_word |=>
      res_valid_o && (res_o.out_index == 4'($past(res_o.out_index) + 4'd1)))
    else $error("Results are not emitted in consecutive index order.");

endmodule

// ----- hw/rtl/s20r_qr_unit.sv -----
// Shared quarter-round unit: four word registers and one add, rotate and xor step.
`timescale 1ns / 1ps

module s20r_qr_unit
  import s20r_pkg::*;
(
  input  logic             clk_i,
  input  qctl_t            ctl_i,
  output logic [WordW-1:0] step_word_o
);

  logic [WordW-1:0]   quad_q [4];
  logic [WordW-1:0]   quad_d [4];
  logic [WordW-1:0]   sum;
  logic [2*WordW-1:0] dbl;

  always_comb begin
    sum         = quad_q[3] + quad_q[0];
    dbl         = {sum, sum} << ctl_i.rot;
    step_word_o = quad_q[1] ^ dbl[2*WordW-1:WordW];
  end

  always_comb begin
    quad_d = quad_q;
    if (ctl_i.load) begin
      quad_d[0] = quad_q[1];
      quad_d[1] = quad_q[2];
      quad_d[2] = quad_q[3];
      quad_d[3] = ctl_i.load_word;
    end else if (ctl_i.step) begin
      if (ctl_i.inverse) begin
        quad_d[0] = quad_q[3];
        quad_d[1] = quad_q[0];
        quad_d[2] = step_word_o;
        quad_d[3] = quad_q[2];
      end else begin
        quad_d[0] = step_word_o;
        quad_d[1] = quad_q[2];
        quad_d[2] = quad_q[3];
        quad_d[3] = quad_q[0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    quad_q <= quad_d;
  end

endmodule

// ----- tb/salsa20_reduced_round_permutation_tb.sv -----
// Testbench that checks the reduced-round Salsa20 permutation against a built-in predictor.
`timescale 1ns / 1ps

module salsa20_reduced_round_permutation_tb;
  import s20r_pkg::*;

  localparam int unsigned StallLimit  = 5000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned RandomItems = 136;

  localparam logic [3:0] ColumnOrder [16] = '{
    4'd0, 4'd4, 4'd8, 4'd12, 4'd5, 4'd9, 4'd13, 4'd1,
    4'd10, 4'd14, 4'd2, 4'd6, 4'd15, 4'd3, 4'd7, 4'd11
  };
  localparam logic [3:0] RowOrder [16] = '{
    4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd6, 4'd7, 4'd4,
    4'd10, 4'd11, 4'd8, 4'd9, 4'd15, 4'd12, 4'd13, 4'd14
  };

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  req_t                req_i;
  logic                res_valid_o;
  res_t                res_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  logic [31:0] state_copy [16];
  logic [4:0]  rounds_copy;
  logic        inverse_copy;
  res_t        expected_words [$];
  int unsigned error_count;
  int unsigned stall_cycles;
  bit          gaps_on;

  salsa20_reduced_round_permutation dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [31:0] rotl32(logic [31:0] v, int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic void quarter_round(logic row, int unsigned grp, logic inv);
    logic [3:0]  ia, ib, ic, id;
    logic [31:0] a, b, c, d;
    ia = row ? RowOrder[4*grp]     : ColumnOrder[4*grp];
    ib = row ? RowOrder[4*grp + 1] : ColumnOrder[4*grp + 1];
    ic = row ? RowOrder[4*grp + 2] : ColumnOrder[4*grp + 2];
    id = row ? RowOrder[4*grp + 3] : ColumnOrder[4*grp + 3];
    a = state_copy[ia];
    b = state_copy[ib];
    c = state_copy[ic];
    d = state_copy[id];
    if (!inv) begin
      b = b ^ rotl32(d + a, 7);
      c = c ^ rotl32(a + b, 9);
      d = d ^ rotl32(b + c, 13);
      a = a ^ rotl32(c + d, 18);
    end else begin
      a = a ^ rotl32(c + d, 18);
      d = d ^ rotl32(b + c, 13);
      c = c ^ rotl32(a + b, 9);
      b = b ^ rotl32(d + a, 7);
    end
    state_copy[ia] = a;
    state_copy[ib] = b;
    state_copy[ic] = c;
    state_copy[id] = d;
  endfunction

  // Applies the configured rounds to the state copy and queues the sixteen words it emits.
  function automatic void permute_state();
    int   r;
    res_t word;
    if (inverse_copy) begin
      for (r = int'(rounds_copy) - 1; r >= 0; r--) begin
        for (int g = 0; g < 4; g++) quarter_round(r[0], g, 1'b1);
      end
    end else begin
      for (r = 0; r < int'(rounds_copy); r++) begin
        for (int g = 0; g < 4; g++) quarter_round(r[0], g, 1'b0);
      end
    end
    for (int k = 0; k < 16; k++) begin
      word.out_word  = state_copy[k];
      word.out_index = k[3:0];
      word.last_word = (k[3:0] == LastIdx);
      expected_words.push_back(word);
    end
  endfunction

  always @(posedge clk_i) begin : track_block
    res_t want;
    logic progress;
    progress = 1'b0;
    if (rst_ni) begin
      if (res_valid_o) begin
        progress = 1'b1;
        if (expected_words.size() == 0) begin
          $error("out_word: expected no result, actual %h", res_o.out_word);
          error_count++;
        end else begin
          want = expected_words.pop_front();
          if (res_o.out_word !== want.out_word) begin
            $error("out_word: expected %h, actual %h", want.out_word, res_o.out_word);
            error_count++;
          end
          if (res_o.out_index !== want.out_index) begin
            $error("out_index: expected %0d, actual %0d", want.out_index, res_o.out_index);
            error_count++;
          end
          if (res_o.last_word !== want.last_word) begin
            $error("last_word: expected %b, actual %b", want.last_word, res_o.last_word);
            error_count++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        progress = 1'b1;
        case (cfg_index_i)
          CfgRoundCount: rounds_copy = cfg_data_i;
          CfgInverse:    inverse_copy = cfg_data_i[0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        progress = 1'b1;
        state_copy[req_i.word_index] = req_i.word_value;
        if (req_i.word_index == LastIdx) permute_state();
      end
      stall_cycles = progress ? 0 : stall_cycles + 1;
    end
  end

  initial begin
    wait (stall_cycles >= StallLimit);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [31:0] random_word();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_word(input logic [3:0] idx, input logic [31:0] value);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= '{word_value: value, word_index: idx};
    do @(posedge clk_i); while (busy);
  endtask

  // Waits until the last run has drained so that the registers may be written.
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk_i);
    while (busy || expected_words.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic configure(input logic [4:0] rounds, input logic inverse);
    if (gaps_on && $urandom_range(0, 2) == 0) repeat ($urandom_range(1, 6)) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CfgRoundCount;
    cfg_data_i  <= rounds;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= CfgInverse;
    cfg_data_i  <= {4'd0, inverse};
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_default_config();
    send_word(4'd0, 32'h0000_0000);
    send_word(4'd1, 32'hFFFF_FFFF);
    send_word(4'd2, 32'hAAAA_AAAA);
    send_word(4'd3, 32'h5555_5555);
    send_word(4'd4, 32'h8000_0000);
    send_word(4'd5, 32'h0000_0001);
    send_word(4'd6, 32'h7FFF_FFFF);
    for (int i = 7; i < 15; i++) send_word(i[3:0], $urandom);
    send_word(LastIdx, 32'hFFFF_FFFF);
    wait_idle();
  endtask

  task automatic test_zero_rounds();
    configure(5'd0, 1'b0);
    send_word(LastIdx, 32'h0000_0000);
    wait_idle();
  endtask

  task automatic test_single_round();
    configure(5'd1, 1'b0);
    send_word(4'd0, 32'hFFFF_FFFF);
    send_word(LastIdx, 32'h0000_0001);
    wait_idle();
    configure(5'd1, 1'b1);
    send_word(LastIdx, state_copy[LastIdx]);
    wait_idle();
  endtask

  task automatic test_inverse_rounds();
    configure(5'd20, 1'b1);
    send_word(LastIdx, $urandom);
    wait_idle();
    configure(5'd20, 1'b0);
    send_word(LastIdx, state_copy[LastIdx]);
    wait_idle();
  endtask

  task automatic test_rounds_above_limit();
    configure(5'd31, 1'b0);
    send_word(LastIdx, $urandom);
    wait_idle();
    configure(5'd31, 1'b1);
    send_word(LastIdx, state_copy[LastIdx]);
    wait_idle();
  endtask

  task automatic test_random_runs();
    int unsigned sent;
    int unsigned stores;
    logic [4:0]  rounds;
    sent = 0;
    gaps_on = 1'b1;
    while (sent < RandomItems) begin
      if (sent > RandomItems - 30) gaps_on = 1'b0;
      if ($urandom_range(0, 1) == 0) begin
        wait_idle();
        case ($urandom_range(0, 5))
          0:       rounds = 5'd0;
          1:       rounds = 5'd31;
          2:       rounds = 5'($urandom_range(0, 31));
          default: rounds = 5'($urandom_range(0, 8));
        endcase
        configure(rounds, 1'($urandom_range(0, 1)));
      end
      stores = $urandom_range(0, 15);
      for (int i = 0; i < stores; i++) begin
        send_word(4'($urandom_range(0, 14)), random_word());
        sent++;
      end
      if ($urandom_range(0, 7) != 0) begin
        send_word(LastIdx, random_word());
        sent++;
      end
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    req_i        = '0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = CfgRoundCount;
    cfg_data_i   = '0;
    rounds_copy  = RoundReset;
    inverse_copy = 1'b0;
    error_count  = 0;
    stall_cycles = 0;
    gaps_on      = 1'b0;
    for (int k = 0; k < 16; k++) state_copy[k] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_default_config();
    test_zero_rounds();
    test_single_round();
    test_inverse_rounds();
    test_rounds_above_limit();
    test_random_runs();

    wait_idle();
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
